// File: rtl/nsd_pkg.sv
// Shared types, constants and helper functions for the noise-shaped dither core.
// No dependencies; every other file in the project imports this package.
`timescale 1ns / 1ps

package nsd_pkg;

    localparam int IN_W         = 32;  // input sample, Q1.31
    localparam int OUT_W        = 24;  // output sample port
    localparam int ST_W         = 32;  // state entries, Q8.24
    localparam int FRAC         = 24;  // fractional bits of internal values
    localparam int ACC_W        = 36;  // running noise accumulator
    localparam int STAGES_DEF   = 16;
    localparam int OUT_BITS_DEF = 24;
    localparam int RAM_AW_MAX   = 5;   // address field wide enough for 32 stages

    localparam logic signed [ST_W-1:0] K097  = 32'sd16273900;  // 0.97 in Q.24
    localparam logic signed [ST_W-1:0] K0475 = 32'sd7969178;   // 0.475 in Q.24

    localparam logic signed [63:0] ST_MAX64 = 64'sd2147483647;
    localparam logic signed [63:0] ST_MIN64 = -64'sd2147483648;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_WR,
        S_M1,
        S_M2,
        S_M3,
        S_UPD,
        S_M4,
        S_SUM,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                   rd_en;
        logic                   we;
        logic [RAM_AW_MAX-1:0]  addr;
        logic signed [ST_W-1:0] wdata;
    } t_ram_req;

    // Saturate a wide signed value to the 32-bit state range.
    function automatic logic signed [ST_W-1:0] sat_st(input logic signed [63:0] v);
        logic signed [ST_W-1:0] r;
        if (v > ST_MAX64) begin
            r = ST_MAX64[ST_W-1:0];
        end else if (v < ST_MIN64) begin
            r = ST_MIN64[ST_W-1:0];
        end else begin
            r = v[ST_W-1:0];
        end
        return r;
    endfunction

    // One step of the xorshift32 generator.
    function automatic logic [31:0] xs32(input logic [31:0] x);
        logic [31:0] t;
        t = x ^ (x << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

    // Top 16 bits of the generator value minus one half, in Q.24 units:
    // ((x >> 16) << 8) - 2^23 is the top bit flipped, then 8 zero bits.
    function automatic logic signed [23:0] unif(input logic [31:0] x);
        return {~x[31], x[30:16], 8'h00};
    endfunction

endpackage

// File: rtl/nsd_in_if.sv
// Input channel of the dither core: valid/ready handshake with one Q1.31 sample.
// Depends on nsd_pkg for the payload width.
`timescale 1ns / 1ps

interface nsd_in_if;
    import nsd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] in_sample;

    modport source (output valid, output in_sample, input ready);
    modport sink   (input valid, input in_sample, output ready);
endinterface

// File: rtl/nsd_out_if.sv
// Output channel of the dither core: valid/ready handshake with the dithered sample.
// Depends on nsd_pkg for the payload width.
`timescale 1ns / 1ps

interface nsd_out_if;
    import nsd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] out_sample;
    logic                    clipped;

    modport source (output valid, output out_sample, output clipped, input ready);
    modport sink   (input valid, input out_sample, input clipped, output ready);
endinterface

// File: rtl/nsd_stage_ram.sv
// Shaping-stage state memory: one port with a shared address for read and write, registered read data.
// Per-entry valid bits make every entry read as zero after reset. Depends on nsd_pkg.
`timescale 1ns / 1ps

module nsd_stage_ram #(
    parameter int DEPTH = nsd_pkg::STAGES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  nsd_pkg::t_ram_req              i_req,
    output logic signed [nsd_pkg::ST_W-1:0] o_rd_data
);
    import nsd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic signed [ST_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]       r_vld;
    logic signed [ST_W-1:0] r_rd_data;
    logic                   r_rd_vld;
    logic [AW-1:0]          w_addr;

    assign w_addr = i_req.addr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[w_addr] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_vld[w_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_vld[w_addr];
            end
        end
    end

    // An entry never written since reset reads as zero through its valid bit.
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// File: rtl/noise_shaped_dither_24bit_core.sv
// Top level of the noise-shaped dither quantizer.
// Depends on nsd_pkg, nsd_in_if, nsd_out_if and nsd_stage_ram.
`timescale 1ns / 1ps

// Usage
// i_in carries one Q1.31 audio sample per transaction; o_out returns one
// OUT_BITS-wide dithered sample, sign-extended to 24 bits, with a clip flag.
// i_cfg_we / i_cfg_wdata load the noise seed (zero is taken as one) straight
// into the random generator; write it only while the core is idle.
// Each sample walks the STAGES shaping stages in turn through the stage memory
// (read, then modify and write back), and then runs the error-feedback term
// through one shared 32x32 multiplier in six steps. In S_OUT the result goes
// into the output register once it is free, and o_out.valid rises; the core
// takes no new sample until the current one has left S_OUT.
// i_in.ready is high only while the core is idle.
// The result sits in an output register; a new sample can be accepted while
// it waits. If the receiver still stalls when the next result is done, the
// core holds that result and accepts nothing until the register frees.
// Reset (synchronous, active low) clears all stage state and the feedback
// terms, sets the seed to one and drops o_out.valid.
module noise_shaped_dither_24bit_core #(
    parameter int STAGES   = nsd_pkg::STAGES_DEF,
    parameter int OUT_BITS = nsd_pkg::OUT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nsd_in_if.sink      i_in,
    nsd_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);
    import nsd_pkg::*;

    localparam int AW = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam int XW = IN_W + OUT_BITS - 8;
    localparam int SW = ((XW > ACC_W) ? XW : ACC_W) + 2;
    localparam int FW = SW - FRAC;
    localparam logic signed [FW-1:0]    F_HI = FW'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
    localparam logic signed [FW-1:0]    F_LO = FW'(-(64'sd1 <<< (OUT_BITS - 1)));
    localparam logic signed [OUT_W-1:0] O_HI = OUT_W'(F_HI);
    localparam logic signed [OUT_W-1:0] O_LO = OUT_W'(F_LO);
    localparam logic [AW-1:0]           LAST_IDX = AW'(STAGES - 1);

    t_state r_state, n_state;

    logic [AW-1:0]           r_idx;
    logic [31:0]             r_rng;
    logic signed [ST_W-1:0]  r_odd;
    logic signed [ST_W-1:0]  r_perr;
    logic signed [ST_W-1:0]  r_n;
    logic signed [ACC_W-1:0] r_a;
    logic signed [ACC_W-1:0] r_ap;
    logic signed [XW-1:0]    r_x;
    logic signed [63:0]      r_p;
    logic signed [SW-1:0]    r_sum;
    logic                    r_out_vld;
    logic signed [OUT_W-1:0] r_out_sample;
    logic                    r_out_clip;

    logic                    w_accept;
    logic                    w_last;
    logic                    w_slot_free;
    logic signed [XW-1:0]    w_x_ext;
    logic [31:0]             w_rng_nx;
    logic signed [ST_W-1:0]  w_st;
    logic signed [ACC_W:0]   w_st_sum;
    logic signed [ST_W-1:0]  w_st_new;
    logic signed [ST_W-1:0]  w_odd_off;
    logic signed [ST_W-1:0]  w_ma;
    logic signed [ST_W-1:0]  w_mb;
    logic signed [63:0]      w_prod;
    logic signed [ST_W-1:0]  w_c;
    logic signed [ST_W-1:0]  w_n1;
    logic signed [ST_W-1:0]  w_n2;
    logic signed [FW-1:0]    w_f;
    logic signed [SW-1:0]    w_fl;
    logic signed [SW:0]      w_err;
    logic signed [FW-1:0]    w_f_sat;
    logic                    w_clip;
    t_ram_req                w_req;

    assign w_accept    = i_in.valid && i_in.ready;
    assign w_last      = (r_idx == LAST_IDX);
    assign w_slot_free = !r_out_vld || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE);

    // Stage memory access: read in S_RD, write back in S_WR.
    assign w_req.rd_en = (r_state == S_RD);
    assign w_req.we    = (r_state == S_WR);
    assign w_req.addr  = RAM_AW_MAX'(r_idx);
    assign w_req.wdata = w_st_new;

    nsd_stage_ram #(
        .DEPTH (STAGES)
    ) u_stage_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .o_rd_data (w_st)
    );

    assign w_x_ext  = XW'(i_in.in_sample);
    assign w_rng_nx = xs32(r_rng);

    // Stage update: state = sat((state + a) / 2), then a loses the new state.
    assign w_st_sum = (ACC_W + 1)'(w_st) + (ACC_W + 1)'(r_ap);
    assign w_st_new = sat_st(64'(w_st_sum >>> 1));

    // Offset by 0.97: a value at or above 0.97 drops by 0.97, a negative one rises by it,
    // a value from zero up to below 0.97 comes back unchanged, and none of the three arms can overflow.
    always_comb begin
        if (r_odd >= K097) begin
            w_odd_off = r_odd - K097;
        end else if (r_odd < 0) begin
            w_odd_off = r_odd + K097;
        end else begin
            w_odd_off = r_odd;
        end
    end

    // Shared multiplier operands.
    always_comb begin
        unique case (r_state)
            S_M2: begin
                w_ma = sat_st(r_p >>> FRAC);
                w_mb = r_n;
            end
            S_M3: begin
                w_ma = sat_st(r_p >>> FRAC);
                w_mb = K0475;
            end
            S_M4: begin
                w_ma = r_n;
                w_mb = K0475;
            end
            default: begin
                w_ma = r_n;
                w_mb = r_n;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    assign w_c  = ST_W'(r_p >>> FRAC);
    assign w_n1 = sat_st(64'(r_n) - 64'(w_c));
    assign w_n2 = sat_st(64'(w_n1) + 64'(r_perr));

    // Floor to an integer, error before saturation, then clamp to OUT_BITS.
    assign w_f   = r_sum[SW-1:FRAC];
    assign w_fl  = {r_sum[SW-1:FRAC], {FRAC{1'b0}}};
    assign w_err = (SW + 1)'(w_fl) - (SW + 1)'(r_x);

    always_comb begin
        if (w_f > F_HI) begin
            w_f_sat = F_HI;
            w_clip  = 1'b1;
        end else if (w_f < F_LO) begin
            w_f_sat = F_LO;
            w_clip  = 1'b1;
        end else begin
            w_f_sat = w_f;
            w_clip  = 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_RD;
                end
            end
            S_RD:  n_state = S_WR;
            S_WR: begin
                n_state = w_last ? S_M1 : S_RD;
            end
            S_M1:  n_state = S_M2;
            S_M2:  n_state = S_M3;
            S_M3:  n_state = S_UPD;
            S_UPD: n_state = S_M4;
            S_M4:  n_state = S_SUM;
            S_SUM: n_state = S_OUT;
            S_OUT: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control and persistent state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_rng     <= 32'd1;
            r_odd     <= '0;
            r_perr    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_rng <= (i_cfg_wdata == 32'd0) ? 32'd1 : i_cfg_wdata;
            end else if (r_state == S_RD) begin
                r_rng <= w_rng_nx;
            end

            if (w_accept) begin
                r_idx <= '0;
            end else if (r_state == S_WR && !w_last) begin
                r_idx <= r_idx + 1'b1;
            end

            if (r_state == S_UPD) begin
                r_odd <= w_n2;
            end

            if (r_state == S_OUT && w_slot_free) begin
                r_perr    <= sat_st(64'(w_err));
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x <= w_x_ext <<< (OUT_BITS - 8);
            r_a <= '0;
            r_n <= w_odd_off;
        end
        unique case (r_state)
            S_RD:  r_ap <= r_a + ACC_W'(unif(w_rng_nx));
            S_WR:  r_a  <= r_ap - ACC_W'(w_st_new);
            S_M1, S_M2, S_M3, S_M4: r_p <= w_prod;
            S_UPD: r_n  <= w_n2;
            S_SUM: r_sum <= SW'(r_a) + SW'(r_x) + SW'(r_p >>> FRAC);
            S_OUT: begin
                if (w_slot_free) begin
                    r_out_sample <= OUT_W'(w_f_sat);
                    r_out_clip   <= w_clip;
                end
            end
            default: ;
        endcase
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.out_sample = r_out_sample;
    assign o_out.clipped    = r_out_clip;

`ifndef SYNTH
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_RD))
        else $error("accepted transaction did not start the stage walk");

    a_ram_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_req.rd_en && w_req.we))
        else $error("stage memory read and written in the same cycle");

    a_stage_walk_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR && w_last) |=> (r_state == S_M1))
        else $error("last stage write not followed by feedback term");

    a_rng_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rng != 32'd0)
        else $error("random generator locked at zero");

    a_clip_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.clipped) |->
            (o_out.out_sample == O_HI || o_out.out_sample == O_LO))
        else $error("clip flag set on a sample inside the range");
`endif

endmodule

// File: bench/noise_shaped_dither_24bit_core_tb.sv
// Self-checking testbench for noise_shaped_dither_24bit_core: a bit-exact predictor of the
// shaped dither, the error feedback and the 24-bit quantizer checks every output transaction.
// Depends on nsd_pkg, nsd_in_if, nsd_out_if and the core itself.
`timescale 1ns / 1ps

module noise_shaped_dither_24bit_core_tb;
    import nsd_pkg::*;

    localparam int     NSTAGE    = 16;
    localparam longint Q24_097   = 16273900;  // 0.97
    localparam longint Q24_0475  = 7969178;   // 0.475
    localparam longint ST_HI     = 64'sd2147483647;
    localparam longint ST_LO     = -64'sd2147483648;
    localparam longint LSB_HI    = 8388607;
    localparam longint LSB_LO    = -8388608;
    localparam int     DRAIN_CYC = 50;
    localparam int     RAND_ITEMS = 126;      // per seed phase

    typedef struct {
        logic signed [OUT_W-1:0] smp;
        logic                    clip;
    } t_dither_out;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [31:0] i_cfg_wdata;

    nsd_in_if  in_ch ();
    nsd_out_if out_ch ();

    noise_shaped_dither_24bit_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // Predictor state, mirrors what the core keeps between samples.
    logic signed [31:0] shaper_st [NSTAGE];
    logic signed [31:0] fb_term;
    logic signed [31:0] last_err;
    logic [31:0]        noise_gen;

    logic signed [31:0] sample_q [$];
    t_dither_out        pending_dither_q [$];

    int  issued_cnt;
    int  accepted_cnt;
    int  dither_seen;
    int  err_cnt;
    bit  in_fire;
    int  burst_left;
    int  gap_left;
    int  rx_cycle;
    int  hold_left;
    bit  hold_done;
    t_dither_out want;
    t_dither_out got;

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > ST_HI) begin
            return 32'sh7FFFFFFF;
        end
        if (v < ST_LO) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Runs one sample through the shaping cascade, the error feedback and the quantizer.
    function automatic t_dither_out predict_dither(input logic signed [31:0] smp);
        t_dither_out r;
        longint xs, acc, sum, f, c, t, u;
        logic signed [31:0] n;
        xs = smp;
        xs = xs * 65536;
        acc = 0;
        for (int i = 0; i < NSTAGE; i++) begin
            noise_gen = noise_gen ^ (noise_gen << 13);
            noise_gen = noise_gen ^ (noise_gen >> 17);
            noise_gen = noise_gen ^ (noise_gen << 5);
            u = noise_gen[31:16];
            u = (u <<< 8) - 8388608;
            acc = acc + u;
            t = shaper_st[i];
            t = (t + acc) >>> 1;
            shaper_st[i] = clamp32(t);
            t = shaper_st[i];
            acc = acc - t;
        end
        sum = acc + xs;

        n = fb_term;
        if (n > 0) begin
            t = n;
            n = clamp32(t - Q24_097);
        end
        if (n < 0) begin
            t = n;
            n = clamp32(t + Q24_097);
        end
        t = n;
        c = clamp32((t * t) >>> 24);
        c = clamp32((c * t) >>> 24);
        c = (c * Q24_0475) >>> 24;
        n = clamp32(t - c);
        t = n;
        c = last_err;
        n = clamp32(t + c);
        fb_term = n;

        t = n;
        sum = sum + ((t * Q24_0475) >>> 24);
        f = sum >>> 24;
        // The fed-back error uses the floored value before output saturation.
        last_err = clamp32(f * 16777216 - xs);

        r.clip = 1'b0;
        if (f > LSB_HI) begin
            f = LSB_HI;
            r.clip = 1'b1;
        end
        if (f < LSB_LO) begin
            f = LSB_LO;
            r.clip = 1'b1;
        end
        r.smp = f[OUT_W-1:0];
        return r;
    endfunction

    function automatic logic signed [31:0] random_sample();
        logic signed [31:0] v;
        case ($urandom_range(0, 4))
            0: v = $urandom;
            1: v = $signed($urandom_range(0, 4095)) - 2048;
            2: v = 32'sh7FFFFFFF - $signed($urandom_range(0, 1 << 20));
            3: v = 32'sh80000000 + $signed($urandom_range(0, 1 << 20));
            default: v = $signed($urandom) >>> $urandom_range(1, 24);
        endcase
        return v;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Input side: predict on every accepted transaction.
    always @(posedge i_clk) begin
        in_fire = i_rst_n && in_ch.valid && in_ch.ready;
        if (in_fire) begin
            pending_dither_q.push_back(predict_dither(in_ch.in_sample));
            accepted_cnt++;
        end
    end

    // Sender: bursts of random length separated by random gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_fire) begin
            if (gap_left > 0) begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end else if (sample_q.size() > 0) begin
                in_ch.valid <= 1'b1;
                in_ch.in_sample <= sample_q.pop_front();
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 50) : 0;
                end else begin
                    burst_left--;
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: always ready, then random, then long periodic stalls; one very long
    // hold-off lets the core fill its output register and block its input.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            rx_cycle++;
            if (!hold_done && dither_seen >= 250) begin
                hold_left = 600;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                case ((rx_cycle / 128) % 3)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= $urandom_range(0, 1);
                    default: out_ch.ready <= (rx_cycle % 53) >= 41;
                endcase
            end
        end
    end

    // Output side: compare each transaction with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            dither_seen++;
            got.smp = out_ch.out_sample;
            got.clip = out_ch.clipped;
            if (pending_dither_q.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected output sample=%0d clipped=%0b",
                         $time, got.smp, got.clip);
            end else begin
                want = pending_dither_q.pop_front();
                if (got.smp !== want.smp) begin
                    err_cnt++;
                    $display("%0t: out_sample expected %0d, got %0d",
                             $time, want.smp, got.smp);
                end
                if (got.clip !== want.clip) begin
                    err_cnt++;
                    $display("%0t: clipped expected %0b, got %0b",
                             $time, want.clip, got.clip);
                end
            end
        end
    end

    task automatic queue_sample(input logic signed [31:0] v);
        sample_q.push_back(v);
        issued_cnt++;
    endtask

    task automatic wait_quiet();
        do begin
            @(negedge i_clk);
        end while (accepted_cnt != issued_cnt || pending_dither_q.size() != 0);
    endtask

    // Seed writes take effect at once; a zero seed is loaded as one.
    task automatic load_noise_seed(input logic [31:0] seed);
        wait_quiet();
        repeat (DRAIN_CYC) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= seed;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        noise_gen = (seed == 32'd0) ? 32'd1 : seed;
    endtask

    initial begin
        logic [31:0] seeds [5];
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 32'd0;
        in_ch.valid = 1'b0;
        in_ch.in_sample = '0;
        out_ch.ready = 1'b0;
        for (int i = 0; i < NSTAGE; i++) begin
            shaper_st[i] = '0;
        end
        fb_term = '0;
        last_err = '0;
        noise_gen = 32'd1;
        burst_left = 1;
        seeds[0] = 32'd0;
        seeds[1] = 32'hFFFFFFFF;
        seeds[2] = $urandom;
        seeds[3] = 32'h80000000;
        seeds[4] = 32'd1;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: silence, full-scale extremes, single LSBs and runs into the clip.
        queue_sample(32'sh00000000);
        queue_sample(32'sh7FFFFFFF);
        queue_sample(32'sh80000000);
        queue_sample(32'sh00000001);
        queue_sample(32'shFFFFFFFF);
        queue_sample(32'sh00000100);
        queue_sample(32'shFFFFFF00);
        queue_sample(32'sh00000080);
        queue_sample(32'sh55555555);
        queue_sample(32'shAAAAAAAA);
        queue_sample(32'sh40000000);
        queue_sample(32'shC0000000);
        repeat (3) queue_sample(32'sh00000000);
        repeat (4) queue_sample(32'sh7FFFFF00);
        repeat (4) queue_sample(32'sh80000000);
        queue_sample(32'sh00000000);

        foreach (seeds[p]) begin
            load_noise_seed(seeds[p]);
            repeat (RAND_ITEMS) queue_sample(random_sample());
        end

        wait_quiet();
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (err_cnt == 0 && pending_dither_q.size() == 0) begin
            $display("noise_shaped_dither_24bit_core_tb: done, clean");
        end else begin
            $display("noise_shaped_dither_24bit_core_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("noise_shaped_dither_24bit_core_tb: done, errors");
        $finish;
    end

endmodule

// File: noise_shaped_dither_24bit_core.f
rtl/nsd_pkg.sv
rtl/nsd_in_if.sv
rtl/nsd_out_if.sv
rtl/nsd_stage_ram.sv
rtl/noise_shaped_dither_24bit_core.sv
bench/noise_shaped_dither_24bit_core_tb.sv
